// ===== sv/line_endpoint_projector_assert.svh =====
// assertion helpers for the line endpoint projector
`ifndef LINE_ENDPOINT_PROJECTOR_ASSERT_SVH
`define LINE_ENDPOINT_PROJECTOR_ASSERT_SVH

`ifndef SYNTHESIS
`define LEP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lep check failed");
`define LEP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lep check failed");
`else
`define LEP_ASSERT_NOW(label, ante, cons)
`define LEP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/lep_pkg.sv =====
`timescale 1ns / 1ps

package lep_pkg;

    localparam int POINT_SLOTS = 256;
    localparam int IDX_W       = $clog2(POINT_SLOTS);
    localparam int CFG_REGS    = 8;
    localparam int CFG_IDX_W   = $clog2(CFG_REGS);
    localparam int CFG_W       = 48;
    localparam int COEF_W      = 24;
    localparam int COORD_W     = 16;
    localparam int POINT_W     = 3 * COORD_W;
    localparam int PROD_W      = COEF_W + COORD_W;
    localparam int V_W         = 42;
    localparam int SUM_W       = V_W + 1;
    localparam int NUM_W       = 52;
    localparam int DEN_W       = V_W + 1;
    localparam int Q_W         = 9;
    localparam int REM_W       = NUM_W - 1;
    localparam int CMP_W       = DEN_W + Q_W + 1;
    localparam int DIV_LAT     = Q_W + 1;
    localparam int BACK_LAT    = 4 + DIV_LAT;

    localparam int SCALE_X = 119;
    localparam int SCALE_Y = 159;
    localparam int SCALE_D = 255;
    localparam logic [Q_W-1:0] X_MAX = Q_W'(238);
    localparam logic [Q_W-1:0] Y_MAX = Q_W'(318);
    localparam logic [Q_W-1:0] D_MAX = Q_W'(255);

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_DRAW = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS01 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS23 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS01 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS23 = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS01 = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS23 = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS01 = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS23 = CFG_IDX_W'(7);

    localparam logic [CFG_W-1:0] COEF_ONE_EVEN = CFG_W'(48'h0100_0000_0000);
    localparam logic [CFG_W-1:0] COEF_ONE_ODD  = CFG_W'(48'h0000_0001_0000);

    typedef logic [POINT_W-1:0] point_t;
    typedef logic [CFG_REGS-1:0][CFG_W-1:0] matrix_t;

    typedef struct packed {
        logic                      mode;
        logic [7:0]                first_index;
        logic [7:0]                second_index;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic [15:0]               line_color;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  start_x;
        logic [8:0]  start_y;
        logic [7:0]  start_depth;
        logic [7:0]  end_x;
        logic [8:0]  end_y;
        logic [7:0]  end_depth;
        logic [15:0] color_out;
        logic        clipped;
    } out_item_t;

    typedef struct packed {
        point_t      p0;
        point_t      p1;
        logic [15:0] color;
    } draw_item_t;

    function automatic logic [CFG_W-1:0] cfg_reset_value(input logic [CFG_IDX_W-1:0] idx);
        logic [CFG_W-1:0] val;
        val = '0;
        unique case (idx)
            REG_ROW0_COLS01: val = COEF_ONE_EVEN;
            REG_ROW1_COLS01: val = COEF_ONE_ODD;
            REG_ROW2_COLS23: val = COEF_ONE_EVEN;
            REG_ROW3_COLS23: val = COEF_ONE_ODD;
            default:         val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== sv/lep_front.sv =====
`timescale 1ns / 1ps

module lep_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lep_pkg::in_item_t   s_data,
    output logic                fq_valid,
    input  logic                fq_ready,
    output lep_pkg::draw_item_t fq_data
);

    lep_pkg::point_t store_mem [lep_pkg::POINT_SLOTS];

    logic                   f_valid_reg;
    lep_pkg::point_t        rd0_reg;
    lep_pkg::point_t        rd1_reg;
    logic [15:0]            color_reg;
    logic                   accept;
    logic                   is_draw;
    logic [lep_pkg::IDX_W-1:0] addr_a;
    logic [lep_pkg::IDX_W-1:0] addr_b;

    assign s_ready = !f_valid_reg || fq_ready;
    assign accept  = s_valid && s_ready;
    assign is_draw = (s_data.mode == lep_pkg::MODE_DRAW);
    assign addr_a  = s_data.first_index[lep_pkg::IDX_W-1:0];
    assign addr_b  = s_data.second_index[lep_pkg::IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (s_ready) begin
            f_valid_reg <= s_valid && is_draw;
        end
    end

    // one write port for loads, two read ports for the endpoints of a draw
    always_ff @(posedge aclk) begin
        if (accept && !is_draw) begin
            store_mem[addr_a] <= {s_data.coord_x, s_data.coord_y, s_data.coord_z};
        end
        if (accept && is_draw) begin
            rd0_reg   <= store_mem[addr_a];
            rd1_reg   <= store_mem[addr_b];
            color_reg <= s_data.line_color;
        end
    end

    assign fq_valid      = f_valid_reg;
    assign fq_data.p0    = rd0_reg;
    assign fq_data.p1    = rd1_reg;
    assign fq_data.color = color_reg;

endmodule

// ===== sv/lep_queue.sv =====
`timescale 1ns / 1ps

module lep_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  lep_pkg::draw_item_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output lep_pkg::draw_item_t out_data
);

    lep_pkg::draw_item_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= in_data;
    end

endmodule

// ===== sv/lep_div.sv =====
`timescale 1ns / 1ps

module lep_div (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [lep_pkg::NUM_W-1:0]    num,
    input  logic [lep_pkg::DEN_W-1:0]           den,
    input  logic                                kill,
    input  logic [lep_pkg::Q_W-1:0]             hi,
    output logic [lep_pkg::Q_W-1:0]             quot
);

    localparam int QW = lep_pkg::Q_W;

    logic [lep_pkg::REM_W-1:0] rem_reg  [QW+1];
    logic [lep_pkg::DEN_W-1:0] den_reg  [QW+1];
    logic [QW-1:0]             q_reg    [QW+1];
    logic                      zero_reg [QW+1];
    logic                      sat_reg  [QW+1];

    logic                      neg;
    logic [lep_pkg::CMP_W-1:0] top_trial;

    assign neg       = num[lep_pkg::NUM_W-1];
    assign top_trial = lep_pkg::CMP_W'(den) << QW;

    // negative numerators and clipped endpoints give zero, quotients past the range saturate
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= num[lep_pkg::REM_W-1:0];
            den_reg[0]  <= den;
            q_reg[0]    <= '0;
            zero_reg[0] <= kill || neg;
            sat_reg[0]  <= lep_pkg::CMP_W'(num[lep_pkg::REM_W-1:0]) >= top_trial;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [lep_pkg::CMP_W-1:0] trial;
        logic [lep_pkg::CMP_W-1:0] rem_ext;
        logic                      take;
        assign trial   = lep_pkg::CMP_W'(den_reg[k-1]) << (QW - k);
        assign rem_ext = lep_pkg::CMP_W'(rem_reg[k-1]);
        assign take    = rem_ext >= trial;
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= take ? lep_pkg::REM_W'(rem_ext - trial) : rem_reg[k-1];
                q_reg[k]    <= q_reg[k-1] | (take ? (QW'(1) << (QW - k)) : '0);
                den_reg[k]  <= den_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
                sat_reg[k]  <= sat_reg[k-1];
            end
        end
    end

    always_comb begin
        priority if (zero_reg[QW]) begin
            quot = '0;
        end else if (sat_reg[QW] || (q_reg[QW] > hi)) begin
            quot = hi;
        end else begin
            quot = q_reg[QW];
        end
    end

endmodule

// ===== sv/lep_point_unit.sv =====
`timescale 1ns / 1ps

module lep_point_unit (
    input  logic                    aclk,
    input  logic                    en,
    input  lep_pkg::point_t         point,
    input  lep_pkg::matrix_t        matrix,
    output logic [lep_pkg::Q_W-1:0] scr_x,
    output logic [lep_pkg::Q_W-1:0] scr_y,
    output logic [lep_pkg::Q_W-1:0] scr_d,
    output logic                    clip
);

    localparam int CW = lep_pkg::COORD_W;
    localparam int KW = lep_pkg::COEF_W;

    logic signed [KW-1:0]              coef  [4][4];
    logic signed [CW-1:0]              coord [3];
    logic signed [lep_pkg::PROD_W-1:0] prod_reg [4][4];
    logic signed [lep_pkg::V_W-1:0]    v_reg [4];
    logic signed [lep_pkg::SUM_W-1:0]  sx_reg, sy_reg, sz_reg;
    logic signed [lep_pkg::V_W-1:0]    w_reg;
    logic                              clip1_reg;
    logic signed [lep_pkg::NUM_W-1:0]  nx_reg, ny_reg, nd_reg;
    logic [lep_pkg::DEN_W-1:0]         denw_reg, den2w_reg;
    logic                              clip2_reg;
    logic                              clip_pipe_reg [lep_pkg::DIV_LAT];

    assign coord[0] = point[3*CW-1:2*CW];
    assign coord[1] = point[2*CW-1:CW];
    assign coord[2] = point[CW-1:0];

    // even column sits in the upper half of each register
    for (genvar r = 0; r < 4; r++) begin : g_row
        for (genvar c = 0; c < 4; c++) begin : g_col
            assign coef[r][c] = (c % 2 == 0) ? matrix[r*2 + c/2][2*KW-1:KW]
                                             : matrix[r*2 + c/2][KW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod_reg[r][c] <= lep_pkg::PROD_W'(coef[r][c]) *
                                      lep_pkg::PROD_W'(coord[c]);
                end
                // implicit w of one in q8.8
                prod_reg[r][3] <= lep_pkg::PROD_W'(coef[r][3]) <<< 8;
            end
            for (int r = 0; r < 4; r++) begin
                v_reg[r] <= lep_pkg::V_W'(prod_reg[r][0]) + lep_pkg::V_W'(prod_reg[r][1])
                          + lep_pkg::V_W'(prod_reg[r][2]) + lep_pkg::V_W'(prod_reg[r][3]);
            end
            sx_reg    <= lep_pkg::SUM_W'(v_reg[3]) + lep_pkg::SUM_W'(v_reg[0]);
            sy_reg    <= lep_pkg::SUM_W'(v_reg[3]) + lep_pkg::SUM_W'(v_reg[1]);
            sz_reg    <= lep_pkg::SUM_W'(v_reg[3]) - lep_pkg::SUM_W'(v_reg[2]);
            w_reg     <= v_reg[3];
            clip1_reg <= (v_reg[3] <= 0);
            nx_reg    <= lep_pkg::NUM_W'(sx_reg) * lep_pkg::NUM_W'(lep_pkg::SCALE_X);
            ny_reg    <= lep_pkg::NUM_W'(sy_reg) * lep_pkg::NUM_W'(lep_pkg::SCALE_Y);
            nd_reg    <= lep_pkg::NUM_W'(sz_reg) * lep_pkg::NUM_W'(lep_pkg::SCALE_D);
            denw_reg  <= lep_pkg::DEN_W'(w_reg);
            den2w_reg <= lep_pkg::DEN_W'(w_reg) << 1;
            clip2_reg <= clip1_reg;
            clip_pipe_reg[0] <= clip2_reg;
            for (int i = 1; i < lep_pkg::DIV_LAT; i++) begin
                clip_pipe_reg[i] <= clip_pipe_reg[i-1];
            end
        end
    end

    lep_div u_div_x (
        .aclk (aclk), .en (en), .num (nx_reg), .den (denw_reg),
        .kill (clip2_reg), .hi (lep_pkg::X_MAX), .quot (scr_x)
    );

    lep_div u_div_y (
        .aclk (aclk), .en (en), .num (ny_reg), .den (denw_reg),
        .kill (clip2_reg), .hi (lep_pkg::Y_MAX), .quot (scr_y)
    );

    lep_div u_div_d (
        .aclk (aclk), .en (en), .num (nd_reg), .den (den2w_reg),
        .kill (clip2_reg), .hi (lep_pkg::D_MAX), .quot (scr_d)
    );

    assign clip = clip_pipe_reg[lep_pkg::DIV_LAT-1];

endmodule

// ===== sv/lep_back.sv =====
`timescale 1ns / 1ps

module lep_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  lep_pkg::matrix_t    matrix,
    input  logic                q_valid,
    output logic                q_ready,
    input  lep_pkg::draw_item_t q_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lep_pkg::out_item_t  m_data
);

    localparam int LAT = lep_pkg::BACK_LAT;

    logic                    en;
    logic                    vld_reg   [LAT];
    logic [15:0]             color_reg [LAT];
    logic                    m_valid_reg;
    lep_pkg::out_item_t      m_data_reg;
    logic [lep_pkg::Q_W-1:0] x0, y0, d0, x1, y1, d1;
    logic                    c0, c1;

    // whole pipe moves together; it holds only while a result waits at the output
    assign en      = !m_valid_reg || m_ready;
    assign q_ready = en;

    lep_point_unit u_pt0 (
        .aclk (aclk), .en (en), .point (q_data.p0), .matrix (matrix),
        .scr_x (x0), .scr_y (y0), .scr_d (d0), .clip (c0)
    );

    lep_point_unit u_pt1 (
        .aclk (aclk), .en (en), .point (q_data.p1), .matrix (matrix),
        .scr_x (x1), .scr_y (y1), .scr_d (d1), .clip (c1)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) vld_reg[i] <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= q_valid;
            for (int i = 1; i < LAT; i++) vld_reg[i] <= vld_reg[i-1];
            m_valid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            color_reg[0] <= q_data.color;
            for (int i = 1; i < LAT; i++) color_reg[i] <= color_reg[i-1];
            if (vld_reg[LAT-1]) begin
                m_data_reg.start_x     <= x0[7:0];
                m_data_reg.start_y     <= y0;
                m_data_reg.start_depth <= d0[7:0];
                m_data_reg.end_x       <= x1[7:0];
                m_data_reg.end_y       <= y1;
                m_data_reg.end_depth   <= d1[7:0];
                m_data_reg.color_out   <= color_reg[LAT-1];
                m_data_reg.clipped     <= c0 || c1;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== sv/line_endpoint_projector.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// s_        in         s_valid / s_ready      lep_pkg::in_item_t (load or draw)
// m_        out        m_valid / m_ready      lep_pkg::out_item_t (one per draw)
// cfg_      in         cfg_valid / cfg_ready  cfg_index (3 bits), cfg_data (48 bits)
//
// one transaction per cycle in, one result per cycle out, while neither channel stalls; a draw
// result passes through the store read, queue, 4 transform stages, 10 divide stages of the
// bit-per-stage divider pipeline and the output register.
// aresetn is synchronous; it loads the identity matrix, the point store holds no reset.
// a stalled m_ channel freezes the back pipe; the 2-deep queue and front register absorb it.

`include "line_endpoint_projector_assert.svh"

module line_endpoint_projector (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  lep_pkg::in_item_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output lep_pkg::out_item_t               m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lep_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lep_pkg::CFG_W-1:0]        cfg_data
);

    lep_pkg::matrix_t    cfg_reg;
    logic                fq_valid, fq_ready;
    lep_pkg::draw_item_t fq_data;
    logic                bq_valid, bq_ready;
    lep_pkg::draw_item_t bq_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < lep_pkg::CFG_REGS; i++) begin
                cfg_reg[i] <= lep_pkg::cfg_reset_value(lep_pkg::CFG_IDX_W'(i));
            end
        end else if (cfg_valid && cfg_ready) begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    lep_front u_front (
        .aclk (aclk), .aresetn (aresetn),
        .s_valid (s_valid), .s_ready (s_ready), .s_data (s_data),
        .fq_valid (fq_valid), .fq_ready (fq_ready), .fq_data (fq_data)
    );

    lep_queue u_queue (
        .aclk (aclk), .aresetn (aresetn),
        .in_valid (fq_valid), .in_ready (fq_ready), .in_data (fq_data),
        .out_valid (bq_valid), .out_ready (bq_ready), .out_data (bq_data)
    );

    lep_back u_back (
        .aclk (aclk), .aresetn (aresetn), .matrix (cfg_reg),
        .q_valid (bq_valid), .q_ready (bq_ready), .q_data (bq_data),
        .m_valid (m_valid), .m_ready (m_ready), .m_data (m_data)
    );

    `LEP_ASSERT_NEXT(a_load_no_result, s_valid && s_ready && (s_data.mode == lep_pkg::MODE_LOAD), !fq_valid)
    `LEP_ASSERT_NEXT(a_draw_enters, s_valid && s_ready && (s_data.mode == lep_pkg::MODE_DRAW), fq_valid)
    `LEP_ASSERT_NOW(a_screen_range, m_valid, (m_data.start_x <= 8'd238) && (m_data.end_x <= 8'd238) && (m_data.start_y <= 9'd318) && (m_data.end_y <= 9'd318))

endmodule
